// ===== design/cta_pkg.sv =====
// Package for the client table with aging: field widths, codes and the
// control bundle broadcast to the cell chain. No dependencies.
package cta_pkg;

    localparam int TABLE_DEPTH = 16;

    localparam int ADDR_W    = 32;
    localparam int PORT_W    = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int OUTCOME_W = 2;
    localparam int COUNT_W   = 5;

    localparam logic [CFG_IDX_W-1:0] REG_SERVICE_PORT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 1'd1;

    localparam logic [OUTCOME_W-1:0] OUT_REFRESHED = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_ADDED     = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_FULL      = 2'd2;

    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd5;

    typedef enum logic [1:0] {
        CMD_IDLE,
        CMD_LOOKUP,
        CMD_AGE,
        CMD_SHIFT
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] seen;
    } t_entry;

    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] now;
        logic [CFG_W-1:0]  timeout;
        logic              found;
    } t_cell_ctrl;

endpackage

// ===== design/cta_cell.sv =====
// One slot of the client table: holds an entry, matches it, ages it and
// shifts down from its upper neighbor during compaction. Uses cta_pkg.
module cta_cell import cta_pkg::*; #(
    parameter int DEPTH = TABLE_DEPTH,
    parameter int IDX   = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_cell_ctrl                       i_ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]       i_total,
    input  t_entry                           i_up_entry,
    input  logic                             i_up_kill,
    input  logic                             i_kill_below,
    output t_entry                           o_entry,
    output logic                             o_kill,
    output logic                             o_kill_upto,
    output logic                             o_hit
);

    localparam int CW = $clog2(DEPTH+1);
    localparam logic [CW-1:0] MY_IDX = CW'(IDX);
    localparam logic [CW-1:0] FULL   = CW'(DEPTH);

    t_entry            r_entry;
    logic              r_kill;
    logic              in_use;
    logic              kill_eff;
    logic              append;
    logic [TIME_W-1:0] age;

    assign in_use   = MY_IDX < i_total;
    assign o_hit    = in_use && (r_entry.addr == i_ctrl.addr) && (r_entry.port == i_ctrl.port);
    assign append   = !i_ctrl.found && (i_total < FULL) && (MY_IDX == i_total);
    assign age      = i_ctrl.now - r_entry.seen;
    assign kill_eff = in_use && r_kill;

    assign o_entry     = r_entry;
    assign o_kill      = r_kill;
    assign o_kill_upto = i_kill_below || kill_eff;

    always_ff @(posedge i_clk) begin
        case (i_ctrl.cmd)
            CMD_LOOKUP: begin
                if (o_hit) begin
                    r_entry.seen <= i_ctrl.now;
                end else if (append) begin
                    r_entry.addr <= i_ctrl.addr;
                    r_entry.port <= i_ctrl.port;
                    r_entry.seen <= i_ctrl.now;
                end
            end
            CMD_SHIFT: begin
                if (o_kill_upto) begin
                    r_entry <= i_up_entry;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kill <= 1'b0;
        end else begin
            case (i_ctrl.cmd)
                CMD_AGE: begin
                    r_kill <= age > {{(TIME_W-CFG_W){1'b0}}, i_ctrl.timeout};
                end
                CMD_SHIFT: begin
                    if (o_kill_upto) begin
                        r_kill <= i_up_kill;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== design/client_table_with_aging.sv =====
// Top level of the client table with aging: sequencer, registers and the
// chain of cta_cell slots. Uses cta_pkg.
//
// Each packet goes through these steps from input transfer to result: every
// slot compares in parallel and the match is refreshed or the source is
// appended; every slot checks its age; the chain closes the gap above the
// lowest expired slot once for each of the E entries that expire on the
// packet (0 to TABLE_DEPTH); the chain finds nothing left to remove; and the
// result register is loaded, once any earlier result in it has been taken.
// The compaction chain removes one entry per cycle. One packet is in work at
// a time; the next one is taken as soon as the result is in the output
// register, even while that result still waits to be taken.
module client_table_with_aging import cta_pkg::*; #(
    parameter int DEPTH = TABLE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [ADDR_W-1:0]    i_src_addr,
    input  logic [PORT_W-1:0]    i_src_port,
    input  logic [TIME_W-1:0]    i_now_seconds,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [PORT_W-1:0]    o_reply_port,
    output logic [OUTCOME_W-1:0] o_outcome,
    output logic [COUNT_W-1:0]   o_entries_now,
    output logic [COUNT_W-1:0]   o_expired_count,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CW = $clog2(DEPTH+1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);
    localparam logic [CW-1:0] ONE  = CW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_AGE,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [ADDR_W-1:0]     r_addr;
    logic [PORT_W-1:0]     r_port;
    logic [TIME_W-1:0]     r_now;
    logic [CFG_W-1:0]      r_service_port;
    logic [CFG_W-1:0]      r_timeout;
    logic [CW-1:0]         r_total;
    logic [CW-1:0]         r_expired;
    logic [OUTCOME_W-1:0]  r_outcome;
    logic                  r_out_valid;
    logic [PORT_W-1:0]     r_reply_port;
    logic [OUTCOME_W-1:0]  r_out_outcome;
    logic [CW-1:0]         r_out_total;
    logic [CW-1:0]         r_out_expired;

    t_cell_ctrl            ctrl;
    t_entry                cell_entry [DEPTH];
    logic [DEPTH-1:0]      cell_kill;
    logic [DEPTH-1:0]      cell_hit;
    logic [DEPTH:0]        kill_chain;
    logic                  found;
    logic                  any_kill;
    logic                  in_xfer;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_state != S_IDLE;
    assign found      = |cell_hit;
    assign any_kill   = kill_chain[DEPTH];
    assign kill_chain[0] = 1'b0;

    always_comb begin
        case (r_state)
            S_LOOKUP: ctrl.cmd = CMD_LOOKUP;
            S_AGE:    ctrl.cmd = CMD_AGE;
            S_SHIFT:  ctrl.cmd = CMD_SHIFT;
            default:  ctrl.cmd = CMD_IDLE;
        endcase
        ctrl.addr    = r_addr;
        ctrl.port    = r_port;
        ctrl.now     = r_now;
        ctrl.timeout = r_timeout;
        ctrl.found   = found;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry up_entry;
        logic   up_kill;
        if (g == DEPTH - 1) begin : g_top
            assign up_entry = '0;
            assign up_kill  = 1'b0;
        end else begin : g_mid
            assign up_entry = cell_entry[g+1];
            assign up_kill  = cell_kill[g+1];
        end
        cta_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_total      (r_total),
            .i_up_entry   (up_entry),
            .i_up_kill    (up_kill),
            .i_kill_below (kill_chain[g]),
            .o_entry      (cell_entry[g]),
            .o_kill       (cell_kill[g]),
            .o_kill_upto  (kill_chain[g+1]),
            .o_hit        (cell_hit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_addr <= i_src_addr;
            r_port <= i_src_port;
            r_now  <= i_now_seconds;
        end
        if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_reply_port  <= r_service_port;
            r_out_outcome <= r_outcome;
            r_out_total   <= r_total;
            r_out_expired <= r_expired;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_service_port <= '0;
            r_timeout      <= TIMEOUT_RESET;
            r_total        <= '0;
            r_expired      <= '0;
            r_outcome      <= OUT_FULL;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_SERVICE_PORT) begin
                    r_service_port <= i_cfg_data;
                end else if (i_cfg_idx == REG_TIMEOUT) begin
                    r_timeout <= i_cfg_data;
                end
            end
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_state <= S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    if (found) begin
                        r_outcome <= OUT_REFRESHED;
                    end else if (r_total < FULL) begin
                        r_outcome <= OUT_ADDED;
                        r_total   <= r_total + ONE;
                    end else begin
                        r_outcome <= OUT_FULL;
                    end
                    r_state <= S_AGE;
                end
                S_AGE: begin
                    r_expired <= '0;
                    r_state   <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (any_kill) begin
                        r_total   <= r_total - ONE;
                        r_expired <= r_expired + ONE;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_reply_port    = r_reply_port;
    assign o_outcome       = r_out_outcome;
    assign o_entries_now   = COUNT_W'(r_out_total);
    assign o_expired_count = COUNT_W'(r_out_expired);

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= FULL)
        else $error("entry count above table depth");

    a_shift_drops_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && any_kill) |=> (r_total == $past(r_total) - ONE))
        else $error("compaction step did not remove exactly one entry");

    a_fresh_survives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOKUP && r_outcome != OUT_FULL && found) |=> (r_total != '0))
        else $error("table empty after a refresh");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_LOOKUP))
        else $error("input transfer did not start a lookup");

    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_outcome == OUT_REFRESHED || o_outcome == OUT_ADDED
                         || o_outcome == OUT_FULL))
        else $error("undefined outcome code on result");

endmodule

// ===== verif/client_table_with_aging_test.sv =====
// Self-checking testbench for client_table_with_aging: sends packets in random bursts or
// back to back, against random or no output stalls, predicts each reply in order and
// compares field by field. Depends on cta_pkg and the design files.
module client_table_with_aging_test;
    timeunit 1ns;
    timeprecision 1ps;
    import cta_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_PACKETS = 160;
    localparam int POOL_MAX      = 24;
    localparam int REPORT_MAX    = 100;

    typedef struct packed {
        logic [PORT_W-1:0]    reply_port;
        logic [OUTCOME_W-1:0] outcome;
        logic [COUNT_W-1:0]   entries_now;
        logic [COUNT_W-1:0]   expired_count;
    } t_reply;

    class reply_tracker;
        logic [ADDR_W-1:0] tbl_addr[TABLE_DEPTH];
        logic [PORT_W-1:0] tbl_port[TABLE_DEPTH];
        logic [TIME_W-1:0] tbl_seen[TABLE_DEPTH];
        int unsigned       tbl_total = 0;
        logic [CFG_W-1:0]  service_port = '0;
        logic [CFG_W-1:0]  timeout = TIMEOUT_RESET;
        t_reply            replies_due[$];
        int unsigned       errors = 0;
        int unsigned       checked = 0;
        int unsigned       most_expired = 0;
        int unsigned       outcome_seen[3] = '{default: 0};

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_SERVICE_PORT) begin
                service_port = val;
            end else if (idx == REG_TIMEOUT) begin
                timeout = val;
            end
        endfunction

        function void note_packet(logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port,
                                  logic [TIME_W-1:0] now);
            int                hit;
            int unsigned       wr;
            int unsigned       gone;
            logic [TIME_W-1:0] age;
            t_reply            r;
            hit = -1;
            wr = 0;
            gone = 0;
            r.outcome = OUT_FULL;
            for (int i = 0; i < tbl_total; i++) begin
                if (hit < 0 && tbl_addr[i] == addr && tbl_port[i] == port) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                tbl_seen[hit] = now;
                r.outcome = OUT_REFRESHED;
            end else if (tbl_total < TABLE_DEPTH) begin
                tbl_addr[tbl_total] = addr;
                tbl_port[tbl_total] = port;
                tbl_seen[tbl_total] = now;
                tbl_total++;
                r.outcome = OUT_ADDED;
            end
            // age pass with wrapping time, survivors close up in order
            for (int rd = 0; rd < tbl_total; rd++) begin
                age = now - tbl_seen[rd];
                if (age > {16'd0, timeout}) begin
                    gone++;
                end else begin
                    tbl_addr[wr] = tbl_addr[rd];
                    tbl_port[wr] = tbl_port[rd];
                    tbl_seen[wr] = tbl_seen[rd];
                    wr++;
                end
            end
            tbl_total = wr;
            r.reply_port = service_port;
            r.entries_now = COUNT_W'(tbl_total);
            r.expired_count = COUNT_W'(gone);
            replies_due.push_back(r);
        endfunction

        function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
            if (want === got) begin
                return 1'b1;
            end
            if (errors < REPORT_MAX) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
            return 1'b0;
        endfunction

        function void check_reply(t_reply got);
            t_reply want;
            bit     ok;
            if (replies_due.size() == 0) begin
                $display("%0t: reply with none pending, expected nothing, actual %h", $time, got);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            ok = field_ok("reply_port", want.reply_port, got.reply_port)
                & field_ok("outcome", want.outcome, got.outcome)
                & field_ok("entries_now", want.entries_now, got.entries_now)
                & field_ok("expired_count", want.expired_count, got.expired_count);
            if (!ok) begin
                errors++;
            end
            checked++;
            outcome_seen[want.outcome]++;
            if (want.expired_count > most_expired) begin
                most_expired = want.expired_count;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [ADDR_W-1:0]    i_src_addr = '0;
    logic [PORT_W-1:0]    i_src_port = '0;
    logic [TIME_W-1:0]    i_now_seconds = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [PORT_W-1:0]    o_reply_port;
    logic [OUTCOME_W-1:0] o_outcome;
    logic [COUNT_W-1:0]   o_entries_now;
    logic [COUNT_W-1:0]   o_expired_count;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_SERVICE_PORT;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    reply_tracker tracker = new();
    int unsigned  cycles = 0;
    int           gap_mode = 0;
    int           burst_left = 0;
    int           stall_mode = 0;
    int           stall_run = 0;

    client_table_with_aging dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies pending", cycles,
                     tracker.replies_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    // output side: check at the edge, then pick the next stall value
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_reply('{o_reply_port, o_outcome, o_entries_now, o_expired_count});
        end
        if (stall_mode == 0) begin
            i_out_stall <= 1'b0;
        end else if (stall_mode == 1) begin
            i_out_stall <= ($urandom_range(0, 3) == 0);
        end else begin
            if (stall_run > 0) begin
                stall_run <= stall_run - 1;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_run <= $urandom_range(1, 10);
            end
            i_out_stall <= (stall_run > 1) || ($urandom_range(0, 7) == 0);
        end
    end

    task automatic send_packet(logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port,
                               logic [TIME_W-1:0] now);
        i_in_valid <= 1'b1;
        i_src_addr <= addr;
        i_src_port <= port;
        i_now_seconds <= now;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_packet(addr, port, now);
        if (gap_mode != 0) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                burst_left = $urandom_range(1, 20);
            end else begin
                burst_left = burst_left - 1;
            end
        end
    endtask

    task automatic drain_replies();
        i_in_valid <= 1'b0;
        while (tracker.replies_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_config(logic [CFG_W-1:0] svc, logic [CFG_W-1:0] tmo);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_SERVICE_PORT;
        i_cfg_data <= svc;
        @(posedge i_clk);
        tracker.write_reg(REG_SERVICE_PORT, svc);
        i_cfg_idx <= REG_TIMEOUT;
        i_cfg_data <= tmo;
        @(posedge i_clk);
        tracker.write_reg(REG_TIMEOUT, tmo);
        i_cfg_we <= 1'b0;
    endtask

    // reset register values: service port 0, timeout 5
    task automatic run_directed();
        send_packet(32'h0000_0000, 16'h0000, 32'h0000_0000);
        send_packet(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_packet(32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0002);  // time wraps forward
        send_packet(32'hFFFF_FFFF, 16'h0000, 32'h0000_0001);  // time steps back
        for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
            send_packet(ADDR_W'(32'h0A00_0000 + i), PORT_W'(16'h8000 + i), 32'd1);
        end
        send_packet(32'hC0A8_0001, 16'd1000, 32'd1);           // table full
        send_packet(32'h0A00_0003, 16'h8003, 32'd6);           // ages exactly at timeout
        send_packet(32'hC0A8_0002, 16'd1000, 32'd12);          // full, every entry expires
        send_packet(32'h0A00_0003, 16'h8003, 32'd12);
        send_packet(32'h0A00_0003, 16'h8004, 32'd12);          // same address, other port
    endtask

    task automatic run_phase(int n, int pool_n);
        logic [ADDR_W-1:0] pool_addr[POOL_MAX];
        logic [PORT_W-1:0] pool_port[POOL_MAX];
        logic [TIME_W-1:0] clock_now;
        logic [TIME_W-1:0] step;
        int                pause_at;
        int                roll;
        int                pick;
        for (int i = 0; i < POOL_MAX; i++) begin
            pool_addr[i] = (i % 3 == 1) ? pool_addr[i-1] : $urandom;
            pool_port[i] = (i % 3 == 2) ? pool_port[i-1] : 16'($urandom);
        end
        clock_now = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 400);
        pause_at = $urandom_range(n / 4, 3 * n / 4);
        for (int k = 0; k < n; k++) begin
            if (k == pause_at) begin
                drain_replies();
            end
            roll = $urandom_range(0, 19);
            if (roll < 3) begin
                send_packet($urandom, 16'($urandom), $urandom);
            end else begin
                roll = $urandom_range(0, 9);
                if (roll < 5) begin
                    step = '0;
                end else if (roll < 8) begin
                    step = $urandom_range(0, tracker.timeout);
                end else if (roll == 8) begin
                    step = tracker.timeout + 1 + $urandom_range(0, 3);
                end else begin
                    step = tracker.timeout;
                end
                if ($urandom_range(0, 29) == 0) begin
                    clock_now = clock_now - $urandom_range(1, 10);
                end else begin
                    clock_now = clock_now + step;
                end
                pick = $urandom_range(0, pool_n - 1);
                send_packet(pool_addr[pick], pool_port[pick], clock_now);
            end
        end
        drain_replies();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gap_mode = 1;
        stall_mode = 1;
        run_directed();
        drain_replies();

        set_config(16'hFFFF, 16'd0);
        stall_mode = 2;
        run_phase(PHASE_PACKETS, 6);

        set_config(16'h0000, 16'hFFFF);
        gap_mode = 0;
        stall_mode = 0;
        run_phase(PHASE_PACKETS, POOL_MAX);

        set_config(16'($urandom), 16'd1000);
        gap_mode = 1;
        stall_mode = 1;
        run_phase(PHASE_PACKETS, 20);

        set_config(16'($urandom), 16'($urandom_range(1, 20)));
        stall_mode = 2;
        run_phase(PHASE_PACKETS, POOL_MAX);

        set_config(16'($urandom), 16'd5);
        gap_mode = 0;
        stall_mode = 1;
        run_phase(PHASE_PACKETS, 12);

        repeat (25) @(posedge i_clk);
        $display("Checked %0d replies over six register settings: %0d refreshed, %0d added,",
                 tracker.checked, tracker.outcome_seen[OUT_REFRESHED],
                 tracker.outcome_seen[OUT_ADDED]);
        $display("%0d refused with the table full, up to %0d entries aged out at once.",
                 tracker.outcome_seen[OUT_FULL], tracker.most_expired);
        if (tracker.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
